### src/usb_standard_request_handler_macros.svh
`ifndef USB_STANDARD_REQUEST_HANDLER_MACROS_SVH
`define USB_STANDARD_REQUEST_HANDLER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define USRH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define USRH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also checks across reset.
`define USRH_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

### src/usrh_pkg.sv
`timescale 1ns / 1ps

package usrh_pkg;

    localparam int STRING_COUNT_DEF = 4;
    localparam int CFG_LEN_W        = 7;
    localparam int CFG_IDX_W        = 3;
    localparam int IN_DATA_W        = 56;
    localparam int OUT_DATA_W       = 40;
    localparam int QUEUE_DEPTH      = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIG_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRING0_LEN = 3'd2;

    localparam logic [CFG_LEN_W-1:0] DEVICE_LEN_RST  = 7'd18;
    localparam logic [CFG_LEN_W-1:0] CONFIG_LEN_RST  = 7'd32;
    localparam logic [CFG_LEN_W-1:0] STRING0_LEN_RST = 7'd4;
    localparam logic [CFG_LEN_W-1:0] DESC_MAX_LEN    = 7'd64;

    // bRequest codes
    localparam logic [7:0] REQ_READ_STATUS   = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
    localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
    localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
    localparam logic [7:0] REQ_GET_DESC      = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
    localparam logic [7:0] REQ_GET_IFACE     = 8'h0A;
    localparam logic [7:0] REQ_SET_IFACE     = 8'h0B;

    // bmRequestType
    localparam logic [7:0] RT_TYPE_MASK = 8'h60;
    localparam logic [7:0] RT_DEV_OUT   = 8'h00;
    localparam logic [7:0] RT_EP_OUT    = 8'h02;
    localparam logic [7:0] RT_DEV_IN    = 8'h80;
    localparam logic [7:0] RT_IFACE_IN  = 8'h81;
    localparam logic [7:0] RT_EP_IN     = 8'h82;

    // endpoint addresses
    localparam logic [7:0] EP1_OUT_ADDR = 8'h01;
    localparam logic [7:0] EP2_IN_ADDR  = 8'h82;
    localparam logic [7:0] EP3_IN_ADDR  = 8'h83;

    // feature selectors
    localparam logic [7:0] FEAT_EP_HALT       = 8'h00;
    localparam logic [7:0] FEAT_REMOTE_WAKEUP = 8'h01;

    // descriptor types
    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_STRING = 8'h03;

    localparam logic [2:0] SEL_DEVICE  = 3'd0;
    localparam logic [2:0] SEL_CONFIG  = 3'd1;
    localparam logic [2:0] SEL_STRING0 = 3'd2;

    typedef enum logic [1:0] {
        ACT_STALL  = 2'd0,
        ACT_ACK    = 2'd1,
        ACT_INLINE = 2'd2,
        ACT_DESC   = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        OP_STALL,
        OP_ACK,
        OP_INLINE,
        OP_STATUS_DEV,
        OP_STATUS_EP,
        OP_HALT_SET,
        OP_HALT_CLR,
        OP_WAKE_SET,
        OP_WAKE_CLR,
        OP_DESC,
        OP_GET_CONFIG,
        OP_SET_CONFIG
    } t_op;

    // classified request, front to back
    typedef struct packed {
        t_op                  op;
        logic [7:0]           arg;   // endpoint bit mask or config value
        logic [CFG_LEN_W-1:0] slen;
        logic [2:0]           sel;
    } t_cmd;

    // result, first member in the highest bits so action lands at bit 0
    typedef struct packed {
        logic                 watch;
        logic [2:0]           toggle;
        logic [2:0]           halt;
        logic [2:0]           sel;
        logic [CFG_LEN_W-1:0] slen;
        logic [7:0]           byte1;
        logic [7:0]           byte0;
        t_action              action;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

### src/usrh_front.sv
`timescale 1ns / 1ps

module usrh_front import usrh_pkg::*; #(
    parameter int STRING_COUNT = STRING_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_LEN_W-1:0] i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_DATA_W-1:0] i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_cmd                 o_cmd
);

    localparam int SIdxW = (STRING_COUNT > 1) ? $clog2(STRING_COUNT) : 1;

    logic [CFG_LEN_W-1:0] r_dev_len;
    logic [CFG_LEN_W-1:0] r_conf_len;
    logic [CFG_LEN_W-1:0] r_str_len [STRING_COUNT];

    logic       r_valid;
    t_cmd       r_cmd;
    t_cmd       n_cmd;

    logic [7:0]           w_rtype;
    logic [7:0]           w_code;
    logic [7:0]           w_vlow;
    logic [7:0]           w_vhigh;
    logic [7:0]           w_ilow;
    logic [15:0]          w_wlen;
    logic [2:0]           w_ep_bit;
    logic [CFG_LEN_W-1:0] w_dlen;
    logic [CFG_LEN_W-1:0] w_dlen_sat;
    logic [2:0]           w_dsel;
    logic                 w_accept;

    assign w_rtype = i_data[7:0];
    assign w_code  = i_data[15:8];
    assign w_vlow  = i_data[23:16];
    assign w_vhigh = i_data[31:24];
    assign w_ilow  = i_data[39:32];
    assign w_wlen  = i_data[55:40];

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_cmd    = r_cmd;

    // config registers; the user must write them only while idle, which the block itself does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_len  <= DEVICE_LEN_RST;
            r_conf_len <= CONFIG_LEN_RST;
            for (int i = 0; i < STRING_COUNT; i++) begin
                r_str_len[i] <= (i == 0) ? STRING0_LEN_RST : '0;
            end
        end else if (i_cfg_wr_en) begin
            if (i_cfg_addr == CFG_DEVICE_LEN) begin
                r_dev_len <= i_cfg_wr_data;
            end
            if (i_cfg_addr == CFG_CONFIG_LEN) begin
                r_conf_len <= i_cfg_wr_data;
            end
            for (int i = 0; i < STRING_COUNT; i++) begin
                if (i_cfg_addr == CFG_STRING0_LEN + CFG_IDX_W'(i)) begin
                    r_str_len[i] <= i_cfg_wr_data;
                end
            end
        end
    end

    always_comb begin
        case (w_ilow)
            EP1_OUT_ADDR: w_ep_bit = 3'b001;
            EP2_IN_ADDR:  w_ep_bit = 3'b010;
            EP3_IN_ADDR:  w_ep_bit = 3'b100;
            default:      w_ep_bit = 3'b000;
        endcase
    end

    // descriptor length lookup and saturation
    always_comb begin
        w_dlen = '0;
        w_dsel = SEL_DEVICE;
        if (w_vhigh == DT_DEVICE) begin
            w_dlen = r_dev_len;
            w_dsel = SEL_DEVICE;
        end else if (w_vhigh == DT_CONFIG) begin
            w_dlen = r_conf_len;
            w_dsel = SEL_CONFIG;
        end else if (w_vhigh == DT_STRING && w_vlow < 8'(STRING_COUNT)) begin
            w_dlen = r_str_len[w_vlow[SIdxW-1:0]];
            w_dsel = SEL_STRING0 + 3'(w_vlow[SIdxW-1:0]);
        end
        w_dlen_sat = (w_dlen > DESC_MAX_LEN) ? DESC_MAX_LEN : w_dlen;
    end

    always_comb begin
        n_cmd      = '0;
        n_cmd.op   = OP_STALL;
        if ((w_rtype & RT_TYPE_MASK) == 8'h00) begin
            case (w_code)
                REQ_READ_STATUS: begin
                    if (w_rtype == RT_DEV_IN) begin
                        n_cmd.op = OP_STATUS_DEV;
                    end else if (w_rtype == RT_IFACE_IN) begin
                        n_cmd.op   = OP_INLINE;
                        n_cmd.slen = 7'd2;
                    end else if (w_rtype == RT_EP_IN && w_ep_bit != 3'b000) begin
                        n_cmd.op  = OP_STATUS_EP;
                        n_cmd.arg = {5'b0, w_ep_bit};
                    end
                end
                REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                    if (w_rtype == RT_EP_OUT && w_vlow == FEAT_EP_HALT) begin
                        if (w_ep_bit != 3'b000) begin
                            n_cmd.op  = (w_code == REQ_SET_FEATURE) ? OP_HALT_SET : OP_HALT_CLR;
                            n_cmd.arg = {5'b0, w_ep_bit};
                        end
                    end else if (w_rtype == RT_DEV_OUT && w_vlow == FEAT_REMOTE_WAKEUP) begin
                        n_cmd.op = (w_code == REQ_SET_FEATURE) ? OP_WAKE_SET : OP_WAKE_CLR;
                    end
                end
                REQ_SET_ADDRESS: begin
                    n_cmd.op = OP_ACK;
                end
                REQ_GET_DESC: begin
                    if (w_dlen_sat != '0) begin
                        n_cmd.op   = OP_DESC;
                        n_cmd.sel  = w_dsel;
                        n_cmd.slen = (w_wlen <= 16'(w_dlen_sat)) ? w_wlen[CFG_LEN_W-1:0]
                                                                 : w_dlen_sat;
                    end
                end
                REQ_GET_CONFIG: begin
                    n_cmd.op = OP_GET_CONFIG;
                end
                REQ_SET_CONFIG: begin
                    n_cmd.op  = OP_SET_CONFIG;
                    n_cmd.arg = w_vlow;
                end
                REQ_GET_IFACE: begin
                    if (w_ilow == 8'h00 || w_ilow == 8'h01) begin
                        n_cmd.op   = OP_INLINE;
                        n_cmd.slen = 7'd1;
                    end
                end
                REQ_SET_IFACE: begin
                    if (w_vlow == 8'h00 && (w_ilow == 8'h00 || w_ilow == 8'h01)) begin
                        n_cmd.op = OP_ACK;
                    end
                end
                default: begin
                    n_cmd.op = OP_STALL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### src/usrh_queue.sv
`timescale 1ns / 1ps

module usrh_queue import usrh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != CntW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

### src/usrh_back.sv
`timescale 1ns / 1ps

module usrh_back import usrh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_cmd    i_cmd,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic       r_valid;
    t_result    r_result;
    t_result    n_result;
    logic [7:0] r_cfg_val;
    logic [7:0] n_cfg_val;
    logic       r_wake;
    logic       n_wake;
    logic [2:0] r_halts;
    logic [2:0] n_halts;
    logic       w_exec;

    assign o_ready  = !r_valid || i_ready;
    assign w_exec   = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_result        = '0;
        n_result.action = ACT_STALL;
        n_cfg_val       = r_cfg_val;
        n_wake          = r_wake;
        n_halts         = r_halts;
        case (i_cmd.op)
            OP_STALL: begin
                n_result.action = ACT_STALL;
            end
            OP_ACK: begin
                n_result.action = ACT_ACK;
            end
            OP_INLINE: begin
                n_result.action = ACT_INLINE;
                n_result.slen   = i_cmd.slen;
            end
            OP_STATUS_DEV: begin
                n_result.action = ACT_INLINE;
                n_result.byte0  = {6'b0, r_wake, 1'b1};   // self powered
                n_result.slen   = 7'd2;
            end
            OP_STATUS_EP: begin
                n_result.action = ACT_INLINE;
                n_result.byte0  = {7'b0, |(r_halts & i_cmd.arg[2:0])};
                n_result.slen   = 7'd2;
            end
            OP_HALT_SET: begin
                n_result.action = ACT_ACK;
                n_halts         = r_halts | i_cmd.arg[2:0];
            end
            OP_HALT_CLR: begin
                n_result.action = ACT_ACK;
                n_halts         = r_halts & ~i_cmd.arg[2:0];
                n_result.toggle = i_cmd.arg[2:0];
            end
            OP_WAKE_SET: begin
                n_result.action = ACT_ACK;
                n_wake          = 1'b1;
            end
            OP_WAKE_CLR: begin
                n_result.action = ACT_ACK;
                n_wake          = 1'b0;
            end
            OP_DESC: begin
                n_result.action = ACT_DESC;
                n_result.slen   = i_cmd.slen;
                n_result.sel    = i_cmd.sel;
            end
            OP_GET_CONFIG: begin
                n_result.action = ACT_INLINE;
                n_result.byte0  = r_cfg_val;
                n_result.slen   = 7'd1;
            end
            OP_SET_CONFIG: begin
                n_result.action = ACT_ACK;
                n_cfg_val       = i_cmd.arg;
                n_result.watch  = (i_cmd.arg != 8'h00);
            end
            default: begin
                n_result.action = ACT_STALL;
            end
        endcase
        n_result.halt = n_halts;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_cfg_val <= '0;
            r_wake    <= 1'b0;
            r_halts   <= '0;
        end else begin
            if (w_exec) begin
                r_valid   <= 1'b1;
                r_cfg_val <= n_cfg_val;
                r_wake    <= n_wake;
                r_halts   <= n_halts;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_result <= n_result;
        end
    end

endmodule

### src/usb_standard_request_handler.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  one decoded SETUP packet per beat
// m_axis    out  m_axis_tvalid/m_axis_tready  one action per beat
// cfg       in   i_cfg_wr_en                  descriptor length registers
//
// Sustained rate is one beat per cycle while m_axis_tready stays high; the front
// register, the two-entry command queue and the back output register run in
// parallel, and each beat is registered in all three on its way to m_axis.
// Synchronous active-low reset clears control state, endpoint halts, remote
// wakeup and configuration value, and reloads the default descriptor lengths.
// Front and back stall independently; the queue holds up to two beats.

module usb_standard_request_handler import usrh_pkg::*; #(
    parameter int STRING_COUNT = STRING_COUNT_DEF   // 1 to 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_LEN_W-1:0]  i_cfg_wr_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // request_type, request_code, value_low, value_high, index_low, length_requested
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // action, data_byte0, data_byte1, send_length, descriptor_select,
    // halt_flags, toggle_clear, suspend_watch, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic    w_q_push_valid;
    logic    w_q_push_ready;
    t_cmd    w_q_push_cmd;
    logic    w_q_pop_valid;
    logic    w_q_pop_ready;
    t_cmd    w_q_pop_cmd;
    t_result w_result;

    // decode + descriptor length lookup
    usrh_front #(
        .STRING_COUNT (STRING_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .o_valid       (w_q_push_valid),
        .i_ready       (w_q_push_ready),
        .o_cmd         (w_q_push_cmd)
    );

    usrh_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_q_push_valid),
        .o_push_ready (w_q_push_ready),
        .i_push_cmd   (w_q_push_cmd),
        .o_pop_valid  (w_q_pop_valid),
        .i_pop_ready  (w_q_pop_ready),
        .o_pop_cmd    (w_q_pop_cmd)
    );

    // device state + output register
    usrh_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_pop_valid),
        .o_ready  (w_q_pop_ready),
        .i_cmd    (w_q_pop_cmd),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {(OUT_DATA_W - RESULT_W)'(0), w_result};

endmodule

### src/usrh_checker.sv
`timescale 1ns / 1ps

`include "usb_standard_request_handler_macros.svh"

module usrh_checker import usrh_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [1:0] w_action;
    logic [2:0] w_halt;
    logic [2:0] w_toggle;
    logic       w_held;
    logic       w_stall_beat;
    logic       w_stall_clean;
    logic       w_toggle_beat;
    logic       w_toggle_ok;
    logic       w_desc_beat;
    logic       w_desc_ok;

    assign w_action = m_axis_tdata[1:0];
    assign w_halt   = m_axis_tdata[30:28];
    assign w_toggle = m_axis_tdata[33:31];

    assign w_held        = m_axis_tvalid && !m_axis_tready;
    assign w_stall_beat  = m_axis_tvalid && w_action == ACT_STALL;
    assign w_stall_clean = m_axis_tdata[27:2] == '0 && w_toggle == '0 && !m_axis_tdata[34];
    assign w_toggle_beat = m_axis_tvalid && w_toggle != '0;
    assign w_toggle_ok   = w_action == ACT_ACK && $countones(w_toggle) == 1
                           && (w_halt & w_toggle) == '0;
    assign w_desc_beat   = m_axis_tvalid && w_action == ACT_DESC;
    assign w_desc_ok     = m_axis_tdata[24:18] <= DESC_MAX_LEN && m_axis_tdata[17:2] == '0
                           && m_axis_tdata[27:25] <= 3'd5;

    `USRH_ASSERT_RESET(a_no_beat_after_reset, !m_axis_tvalid, "result beat right after reset")

    `USRH_ASSERT_NEXT(a_hold_valid, w_held, m_axis_tvalid, "result beat dropped while stalled")

    `USRH_ASSERT_SAME(a_stall_empty, w_stall_beat, w_stall_clean, "stall carries payload")

    `USRH_ASSERT_SAME(a_toggle_on_clear, w_toggle_beat, w_toggle_ok, "toggle clear without halt clear")

    `USRH_ASSERT_SAME(a_desc_bounds, w_desc_beat, w_desc_ok, "descriptor beat out of range")

endmodule

bind usb_standard_request_handler usrh_checker u_usrh_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import usrh_pkg::*;

    // bRequest codes the block must refuse; not in the package
    localparam logic [7:0] REQ_SET_DESCRIPTOR = 8'h07;
    localparam logic [7:0] REQ_SYNCH_FRAME    = 8'h0C;

    localparam int PHASES      = 7;
    localparam int PHASE_BEATS = 250;
    localparam int LONG_HOLD   = 300;   // receiver hold-off that backs the block up
    localparam int SETTLE      = 8;     // settle time after the last answer comes back

    // Tracks the chapter 9 state and queues the answer each SETUP beat must get.
    class setup_answer_board;
        logic [CFG_LEN_W-1:0] dev_len;
        logic [CFG_LEN_W-1:0] cfg_len;
        logic [CFG_LEN_W-1:0] str_len [4];
        logic [7:0]           cfg_value;
        logic                 wakeup;
        logic [2:0]           halts;
        t_result              pending_answers [$];
        int                   failures;
        int                   beats;
        int                   action_seen [4];

        function new();
            dev_len    = DEVICE_LEN_RST;
            cfg_len    = CONFIG_LEN_RST;
            str_len[0] = STRING0_LEN_RST;
            str_len[1] = '0;
            str_len[2] = '0;
            str_len[3] = '0;
            cfg_value  = '0;
            wakeup     = 1'b0;
            halts      = '0;
            failures   = 0;
            beats      = 0;
            foreach (action_seen[k]) action_seen[k] = 0;
        endfunction

        function void set_length(logic [CFG_IDX_W-1:0] idx, logic [CFG_LEN_W-1:0] v);
            case (idx)
                CFG_DEVICE_LEN: dev_len = v;
                CFG_CONFIG_LEN: cfg_len = v;
                default:        str_len[2'(idx - CFG_STRING0_LEN)] = v;
            endcase
        endfunction

        function logic [2:0] ep_mask(logic [7:0] addr);
            if (addr == EP1_OUT_ADDR) return 3'b001;
            if (addr == EP2_IN_ADDR)  return 3'b010;
            if (addr == EP3_IN_ADDR)  return 3'b100;
            return 3'b000;
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        // Work out the answer for an accepted SETUP beat and update the state.
        function void note_setup(logic [IN_DATA_W-1:0] d);
            t_result              r;
            logic [7:0]           rtype, code, vlow, vhigh, ilow;
            logic [15:0]          wlen;
            logic [2:0]           epm;
            logic [CFG_LEN_W-1:0] dlen;
            rtype = d[7:0];
            code  = d[15:8];
            vlow  = d[23:16];
            vhigh = d[31:24];
            ilow  = d[39:32];
            wlen  = d[55:40];
            r = '0;
            r.action = ACT_STALL;
            epm = ep_mask(ilow);
            // class, vendor and reserved types always stall
            if ((rtype & RT_TYPE_MASK) == 8'h00) begin
                case (code)
                    REQ_READ_STATUS: begin
                        if (rtype == RT_DEV_IN) begin
                            r.action = ACT_INLINE;
                            r.byte0  = {6'd0, wakeup, 1'b1};   // self powered
                            r.slen   = 7'd2;
                        end else if (rtype == RT_IFACE_IN) begin
                            r.action = ACT_INLINE;
                            r.slen   = 7'd2;
                        end else if (rtype == RT_EP_IN && epm != 3'b000) begin
                            r.action = ACT_INLINE;
                            r.byte0  = {7'd0, (halts & epm) != 3'b000};
                            r.slen   = 7'd2;
                        end
                    end
                    REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                        if (rtype == RT_EP_OUT && vlow == FEAT_EP_HALT) begin
                            if (epm != 3'b000) begin
                                if (code == REQ_SET_FEATURE) begin
                                    halts = halts | epm;
                                end else begin
                                    halts    = halts & ~epm;
                                    r.toggle = epm;
                                end
                                r.action = ACT_ACK;
                            end
                        end else if (rtype == RT_DEV_OUT && vlow == FEAT_REMOTE_WAKEUP) begin
                            wakeup   = (code == REQ_SET_FEATURE);
                            r.action = ACT_ACK;
                        end
                    end
                    REQ_SET_ADDRESS: r.action = ACT_ACK;
                    REQ_GET_DESC: begin
                        dlen = '0;
                        if (vhigh == DT_DEVICE) begin
                            dlen  = dev_len;
                            r.sel = SEL_DEVICE;
                        end else if (vhigh == DT_CONFIG) begin
                            dlen  = cfg_len;
                            r.sel = SEL_CONFIG;
                        end else if (vhigh == DT_STRING && vlow < STRING_COUNT_DEF) begin
                            dlen  = str_len[vlow[1:0]];
                            r.sel = SEL_STRING0 + vlow[2:0];
                        end
                        if (dlen > DESC_MAX_LEN) dlen = DESC_MAX_LEN;
                        if (dlen != '0) begin
                            r.action = ACT_DESC;
                            r.slen   = (wlen <= 16'(dlen)) ? wlen[6:0] : dlen;
                        end else begin
                            r.sel = SEL_DEVICE;
                        end
                    end
                    REQ_GET_CONFIG: begin
                        r.action = ACT_INLINE;
                        r.byte0  = cfg_value;
                        r.slen   = 7'd1;
                    end
                    REQ_SET_CONFIG: begin
                        cfg_value = vlow;
                        r.watch   = (vlow != 8'd0);
                        r.action  = ACT_ACK;
                    end
                    REQ_GET_IFACE: begin
                        if (ilow <= 8'd1) begin
                            r.action = ACT_INLINE;
                            r.slen   = 7'd1;
                        end
                    end
                    REQ_SET_IFACE: begin
                        if (vlow == 8'd0 && ilow <= 8'd1) r.action = ACT_ACK;
                    end
                    default: ;
                endcase
            end
            r.halt = halts;
            pending_answers.push_back(r);
            beats++;
            action_seen[r.action]++;
        endfunction

        function void check_answer(logic [OUT_DATA_W-1:0] d);
            t_result want, got;
            logic    bad;
            got = t_result'(d[RESULT_W-1:0]);
            if (pending_answers.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result beat %h with no request waiting", d);
                return;
            end
            want = pending_answers.pop_front();
            bad = got.action !== want.action || got.byte0 !== want.byte0
                || got.byte1 !== want.byte1 || got.slen !== want.slen
                || got.sel !== want.sel || got.halt !== want.halt
                || got.toggle !== want.toggle || got.watch !== want.watch
                || d[OUT_DATA_W-1:RESULT_W] !== '0;
            if (bad) begin
                failures++;
                if (failures <= 10) begin
                    $display("ERROR: mismatch at %0t", $realtime);
                    $display("  exp act=%0d b0=%h b1=%h len=%0d sel=%0d halt=%b tog=%b wat=%b",
                             want.action, want.byte0, want.byte1, want.slen, want.sel,
                             want.halt, want.toggle, want.watch);
                    $display("  got act=%0d b0=%h b1=%h len=%0d sel=%0d halt=%b tog=%b wat=%b pad=%b",
                             got.action, got.byte0, got.byte1, got.slen, got.sel,
                             got.halt, got.toggle, got.watch, d[OUT_DATA_W-1:RESULT_W]);
                end
            end
        endfunction

        function void close_out();
            if (pending_answers.size() != 0) begin
                failures += pending_answers.size();
                $display("ERROR: %0d expected results never arrived", pending_answers.size());
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_LEN_W-1:0]  i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // idle switches per phase, read by the sender and the receiver
    logic send_idle_off = 1'b0;
    logic recv_idle_off = 1'b0;

    setup_answer_board board;

    usb_standard_request_handler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // request_type, request_code, value_low, value_high, index_low, length_requested
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // action, data_byte0, data_byte1, send_length, descriptor_select,
        // halt_flags, toggle_clear, suspend_watch, zero pad
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop; the slowest legal run needs well under a tenth of this.
    initial begin
        #5_000_000;
        $display("ERROR: timeout, %0d results still outstanding", board.pending());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [IN_DATA_W-1:0] pack_setup(
        logic [7:0] rtype, logic [7:0] code, logic [7:0] vlow,
        logic [7:0] vhigh, logic [7:0] ilow, logic [15:0] wlen);
        return {wlen, ilow, vhigh, vlow, code, rtype};
    endfunction

    function automatic int send_gap();
        return send_idle_off ? 0 : $urandom_range(0, 17);
    endfunction

    // mostly our three endpoints, sometimes any address
    function automatic logic [7:0] pick_endpoint();
        case ($urandom_range(0, 3))
            0:       return EP1_OUT_ADDR;
            1:       return EP2_IN_ADDR;
            2:       return EP3_IN_ADDR;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed standard requests with random payload; the rest is
    // class/vendor traffic, unknown codes and raw noise.
    function automatic logic [IN_DATA_W-1:0] random_setup();
        logic [7:0]  rtype, code, vlow, vhigh, ilow;
        logic [15:0] wlen;
        rtype = RT_DEV_IN;
        code  = 8'($urandom);
        vlow  = 8'($urandom);
        vhigh = 8'($urandom);
        ilow  = 8'($urandom);
        wlen  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
        case ($urandom_range(0, 19))
            0, 1: begin
                code = REQ_READ_STATUS;
                case ($urandom_range(0, 3))
                    0:       rtype = RT_DEV_IN;
                    1:       rtype = RT_IFACE_IN;
                    default: rtype = RT_EP_IN;
                endcase
                ilow = pick_endpoint();
            end
            2, 3, 4: begin
                rtype = RT_EP_OUT;
                code  = $urandom_range(0, 1) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
                if ($urandom_range(0, 7) != 0) vlow = FEAT_EP_HALT;
                ilow  = pick_endpoint();
            end
            5: begin
                rtype = RT_DEV_OUT;
                code  = $urandom_range(0, 1) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
                if ($urandom_range(0, 7) != 0) vlow = FEAT_REMOTE_WAKEUP;
            end
            6: begin
                rtype = RT_DEV_OUT;
                code  = REQ_SET_ADDRESS;
            end
            7, 8, 9, 10: begin
                code = REQ_GET_DESC;
                case ($urandom_range(0, 4))
                    0:       vhigh = DT_DEVICE;
                    1:       vhigh = DT_CONFIG;
                    2, 3:    vhigh = DT_STRING;
                    default: ;
                endcase
                if ($urandom_range(0, 7) != 0) vlow = 8'($urandom_range(0, 5));
            end
            11: code = REQ_GET_CONFIG;
            12: begin
                rtype = RT_DEV_OUT;
                code  = REQ_SET_CONFIG;
                if ($urandom_range(0, 2) == 0) vlow = 8'd0;
            end
            13: begin
                rtype = RT_IFACE_IN;
                code  = REQ_GET_IFACE;
                ilow  = 8'($urandom_range(0, 2));
            end
            14: begin
                rtype = 8'($urandom) & ~RT_TYPE_MASK;
                code  = REQ_SET_IFACE;
                vlow  = 8'($urandom_range(0, 1));
                ilow  = 8'($urandom_range(0, 2));
            end
            15: begin
                // class, vendor or reserved type
                rtype = 8'($urandom) | (8'($urandom_range(1, 3)) << 5);
                code  = 8'($urandom_range(0, 11));
            end
            16: rtype = 8'($urandom) & ~RT_TYPE_MASK;
            default: begin
                rtype = 8'($urandom);
                wlen  = 16'($urandom);
            end
        endcase
        return pack_setup(rtype, code, vlow, vhigh, ilow, wlen);
    endfunction

    // Called at a clock edge; returns at the edge where the beat is taken.
    task automatic send_setup(logic [IN_DATA_W-1:0] d, int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_setup(d);
    endtask

    task automatic take_answers();
        int stall;
        int taken = 0;
        forever begin
            stall = recv_idle_off ? 0 : $urandom_range(0, 17);
            // now and then hold off long so the block backs up to its input
            if (taken % 400 == 150) stall = LONG_HOLD;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            board.check_answer(m_axis_tdata);
            taken++;
        end
    endtask

    // Stop offering, let every answer come back, then let the pipe settle.
    task automatic drain();
        int waited = 0;
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_lengths(logic [CFG_LEN_W-1:0] lens [6]);
        for (int k = 0; k < 6; k++) begin
            i_cfg_wr_en   <= 1'b1;
            i_cfg_addr    <= CFG_DEVICE_LEN + 3'(k);
            i_cfg_wr_data <= lens[k];
            board.set_length(CFG_DEVICE_LEN + 3'(k), lens[k]);
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // Runs at reset lengths: device 18, config 32, string0 4, strings 1-3 empty.
    task automatic run_directed();
        send_setup(pack_setup(RT_DEV_IN, REQ_READ_STATUS, 8'd0, 8'd0, 8'd0, 16'd2), send_gap());
        send_setup(pack_setup(RT_DEV_OUT, REQ_SET_FEATURE, FEAT_REMOTE_WAKEUP, 8'd0, 8'd0,
                              16'd0), send_gap());
        send_setup(pack_setup(RT_DEV_IN, REQ_READ_STATUS, 8'd0, 8'd0, 8'd0, 16'd2), send_gap());
        send_setup(pack_setup(RT_DEV_OUT, REQ_CLEAR_FEATURE, FEAT_REMOTE_WAKEUP, 8'd0, 8'd0,
                              16'd0), send_gap());
        send_setup(pack_setup(RT_IFACE_IN, REQ_READ_STATUS, 8'd0, 8'd0, 8'd1, 16'd2),
                   send_gap());
        // halt all three endpoints, then read one back
        send_setup(pack_setup(RT_EP_OUT, REQ_SET_FEATURE, FEAT_EP_HALT, 8'd0, EP1_OUT_ADDR,
                              16'd0), send_gap());
        send_setup(pack_setup(RT_EP_OUT, REQ_SET_FEATURE, FEAT_EP_HALT, 8'd0, EP2_IN_ADDR,
                              16'd0), send_gap());
        send_setup(pack_setup(RT_EP_OUT, REQ_SET_FEATURE, FEAT_EP_HALT, 8'd0, EP3_IN_ADDR,
                              16'd0), send_gap());
        send_setup(pack_setup(RT_EP_IN, REQ_READ_STATUS, 8'd0, 8'd0, EP2_IN_ADDR, 16'd2),
                   send_gap());
        // endpoints we do not have stall
        send_setup(pack_setup(RT_EP_IN, REQ_READ_STATUS, 8'd0, 8'd0, 8'h81, 16'd2), send_gap());
        send_setup(pack_setup(RT_EP_OUT, REQ_SET_FEATURE, FEAT_EP_HALT, 8'd0, 8'h02, 16'd0),
                   send_gap());
        // clear halt pulses the toggle; wrong selector for an endpoint stalls
        send_setup(pack_setup(RT_EP_OUT, REQ_CLEAR_FEATURE, FEAT_EP_HALT, 8'd0, EP2_IN_ADDR,
                              16'd0), send_gap());
        send_setup(pack_setup(RT_EP_OUT, REQ_CLEAR_FEATURE, FEAT_REMOTE_WAKEUP, 8'd0,
                              EP1_OUT_ADDR, 16'd0), send_gap());
        send_setup(pack_setup(RT_DEV_OUT, REQ_SET_ADDRESS, 8'h7F, 8'd0, 8'd0, 16'd0), send_gap());
        // descriptors: clipped, zero wLength, short wLength, empty string, index too high, bad type
        send_setup(pack_setup(RT_DEV_IN, REQ_GET_DESC, 8'd0, DT_DEVICE, 8'd0, 16'hFFFF),
                   send_gap());
        send_setup(pack_setup(RT_DEV_IN, REQ_GET_DESC, 8'd0, DT_CONFIG, 8'd0, 16'd0), send_gap());
        send_setup(pack_setup(RT_DEV_IN, REQ_GET_DESC, 8'd0, DT_STRING, 8'd0, 16'd2), send_gap());
        send_setup(pack_setup(RT_DEV_IN, REQ_GET_DESC, 8'd1, DT_STRING, 8'd0, 16'd64),
                   send_gap());
        send_setup(pack_setup(RT_DEV_IN, REQ_GET_DESC, 8'd4, DT_STRING, 8'd0, 16'd64),
                   send_gap());
        send_setup(pack_setup(RT_DEV_IN, REQ_GET_DESC, 8'd0, 8'h22, 8'd0, 16'd64), send_gap());
        send_setup(pack_setup(RT_DEV_OUT, REQ_SET_CONFIG, 8'hFF, 8'd0, 8'd0, 16'd0), send_gap());
        send_setup(pack_setup(RT_DEV_IN, REQ_GET_CONFIG, 8'd0, 8'd0, 8'd0, 16'd1), send_gap());
        send_setup(pack_setup(RT_DEV_OUT, REQ_SET_CONFIG, 8'd0, 8'd0, 8'd0, 16'd0), send_gap());
        send_setup(pack_setup(RT_IFACE_IN, REQ_GET_IFACE, 8'd0, 8'd0, 8'd2, 16'd1), send_gap());
        send_setup(pack_setup(RT_DEV_OUT, REQ_SET_IFACE, 8'd1, 8'd0, 8'd1, 16'd0), send_gap());
        send_setup(pack_setup(RT_DEV_OUT, REQ_SET_DESCRIPTOR, 8'd0, DT_DEVICE, 8'd0, 16'd18),
                   send_gap());
        send_setup(pack_setup(RT_EP_IN, REQ_SYNCH_FRAME, 8'd0, 8'd0, EP3_IN_ADDR, 16'd2),
                   send_gap());
        // class-type status read, then all ones
        send_setup(pack_setup(8'hA1, REQ_READ_STATUS, 8'd0, 8'd0, 8'd0, 16'd2), send_gap());
        send_setup('1, send_gap());
    endtask

    initial begin
        logic [CFG_LEN_W-1:0] lens [6];
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            take_answers();
        join_none

        run_directed();

        for (int p = 0; p < PHASES; p++) begin
            drain();
            // length settings: all max, all empty, oversized, all one, then random
            for (int k = 0; k < 6; k++) begin
                case (p)
                    0:       lens[k] = DESC_MAX_LEN;
                    1:       lens[k] = '0;
                    2:       lens[k] = (k == 0) ? 7'd127 : 7'($urandom_range(65, 127));
                    3:       lens[k] = 7'd1;
                    default: lens[k] = ($urandom_range(0, 3) == 0) ? 7'd0
                                                                    : 7'($urandom_range(1, 64));
                endcase
            end
            load_lengths(lens);
            send_idle_off = (p == 4 || p == 6);
            recv_idle_off = (p == 4 || p == 5);
            repeat (PHASE_BEATS) send_setup(random_setup(), send_gap());
        end

        drain();
        board.close_out();
        $display("Covered %0d SETUP beats under %0d length settings plus reset values.",
                 board.beats, PHASES);
        $display("Answers: %0d stall, %0d ack, %0d inline, %0d descriptor.",
                 board.action_seen[ACT_STALL], board.action_seen[ACT_ACK],
                 board.action_seen[ACT_INLINE], board.action_seen[ACT_DESC]);
        if (board.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d failures", board.failures);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### usb_standard_request_handler.f
+incdir+src
src/usrh_pkg.sv
src/usrh_front.sv
src/usrh_queue.sv
src/usrh_back.sv
src/usb_standard_request_handler.sv
src/usrh_checker.sv
bench/testbench.sv
